FILE: src/mmrq_pkg.sv
// Shared types, codes and constants for the multi-mailbox ring queue.
`default_nettype none
package mmrq_pkg;

	// Default sizes for the top-level parameters, and the request FIFO depth
	localparam int DEF_MAILBOXES    = 8;
	localparam int DEF_SLOTS        = 16;
	localparam int DEF_MESSAGE_BITS = 32;
	localparam int QUEUE_DEPTH      = 2;

	// Fixed field widths
	localparam int ACTION_W  = 2;
	localparam int ID_W      = 4;
	localparam int MSG_IN_W  = 32;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 4;
	localparam int KIND_W    = 3;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_SEND = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RECV = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_MAILBOX = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;

	// Classified request kinds handed from front to back
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t K_BAD_ID = 3'd0;
	localparam kind_t K_NO_BOX = 3'd1;
	localparam kind_t K_SEND   = 3'd2;
	localparam kind_t K_RECV   = 3'd3;
	localparam kind_t K_PEEK   = 3'd4;
	localparam kind_t K_NOP    = 3'd5;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     mailbox_id;
		logic [MSG_IN_W-1:0] message_in;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MSG_IN_W-1:0] message_out;
	} result_t;

	function automatic int box_width(input int n);
		int w;
		w = (n > 1) ? $clog2(n) : 1;
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: src/multi_mailbox_ring_queue.sv
// Top level of the multi-mailbox ring queue.
// A request is written into the request FIFO; the back end registers its result with done.
// Throughput: one request per cycle; the back end retires one request each cycle it
// holds one, limited by the single pointer read-modify-write and one store port.
// busy stays low: the back end drains every entry the cycle after it lands, so the
// two-entry request FIFO never holds more than one; done can never be held off.
// Reset (arst_n low): all head and tail pointers to zero, mailbox count to 8, FIFO empty.
`default_nettype none
module multi_mailbox_ring_queue #(
	parameter int MAILBOXES    = mmrq_pkg::DEF_MAILBOXES,
	parameter int SLOTS        = mmrq_pkg::DEF_SLOTS,
	parameter int MESSAGE_BITS = mmrq_pkg::DEF_MESSAGE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire mmrq_pkg::request_t            request,
	output logic                               done,
	output mmrq_pkg::result_t                  result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mmrq_pkg::COUNT_W-1:0]  cfg_data
);
	// One FIFO entry: classified kind, zero-based mailbox index, stored word
	localparam int ENTRY_W =
		mmrq_pkg::KIND_W + mmrq_pkg::box_width(MAILBOXES) + MESSAGE_BITS;

	logic               push;
	logic               pop;
	logic               q_valid;
	logic               q_full;
	logic [ENTRY_W-1:0] push_entry;
	logic [ENTRY_W-1:0] head_entry;

	// Hold off new requests only while the FIFO is full
	assign busy = q_full;

	// Front: check the id against the configured count, classify the request
	mmrq_front #(
		.MAILBOXES    (MAILBOXES),
		.MESSAGE_BITS (MESSAGE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.full      (q_full),
		.push      (push),
		.entry     (push_entry)
	);

	// Decouple classification from execution
	mmrq_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (mmrq_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.valid     (q_valid),
		.head_data (head_entry),
		.full      (q_full)
	);

	// Back: advance pointers with wrap, access the store, register the result
	mmrq_back #(
		.MAILBOXES    (MAILBOXES),
		.SLOTS        (SLOTS),
		.MESSAGE_BITS (MESSAGE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (q_valid),
		.entry  (head_entry),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule
`default_nettype wire

FILE: src/mmrq_front.sv
// Front end: mailbox count register and request classification.
`default_nettype none
module mmrq_front #(
	parameter int MAILBOXES    = mmrq_pkg::DEF_MAILBOXES,
	parameter int MESSAGE_BITS = mmrq_pkg::DEF_MESSAGE_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire mmrq_pkg::request_t   request,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [mmrq_pkg::COUNT_W-1:0] cfg_data,
	input  wire logic                 full,
	output logic                      push,
	output logic [mmrq_pkg::KIND_W+mmrq_pkg::box_width(MAILBOXES)+MESSAGE_BITS-1:0] entry
);
	localparam int BOX_W = mmrq_pkg::box_width(MAILBOXES);

	logic [mmrq_pkg::COUNT_W-1:0] count_q;
	mmrq_pkg::kind_t              kind;
	logic [mmrq_pkg::ID_W-1:0]    id_m1;
	logic [BOX_W-1:0]             box;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= mmrq_pkg::COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	always_comb begin
		if (request.mailbox_id == '0) begin
			kind = mmrq_pkg::K_BAD_ID;
		end else if ((request.mailbox_id > count_q) ||
				(int'(request.mailbox_id) > MAILBOXES)) begin
			kind = mmrq_pkg::K_NO_BOX;
		end else begin
			unique case (request.action)
				mmrq_pkg::ACT_SEND: kind = mmrq_pkg::K_SEND;
				mmrq_pkg::ACT_RECV: kind = mmrq_pkg::K_RECV;
				mmrq_pkg::ACT_PEEK: kind = mmrq_pkg::K_PEEK;
				default:            kind = mmrq_pkg::K_NOP;
			endcase
		end
	end

	assign id_m1 = request.mailbox_id - mmrq_pkg::ID_W'(1);
	assign box   = BOX_W'(id_m1);
	assign push  = start && !full;
	assign entry = {kind, box, MESSAGE_BITS'(request.message_in)};

endmodule
`default_nettype wire

FILE: src/mmrq_queue.sv
// Short FIFO between the front end and the back end.
`default_nettype none
module mmrq_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mmrq_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      head_data,
	output logic                  full
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign valid     = (cnt_q != '0);
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign head_data = slot_q[rd_q];
	assign do_pop    = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/mmrq_back.sv
// Back end: per-mailbox pointers, message store and result register.
`default_nettype none
module mmrq_back #(
	parameter int MAILBOXES    = mmrq_pkg::DEF_MAILBOXES,
	parameter int SLOTS        = mmrq_pkg::DEF_SLOTS,
	parameter int MESSAGE_BITS = mmrq_pkg::DEF_MESSAGE_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  valid,
	input  wire logic [mmrq_pkg::KIND_W+mmrq_pkg::box_width(MAILBOXES)+MESSAGE_BITS-1:0] entry,
	output logic       pop,
	output logic       done,
	output mmrq_pkg::result_t result
);
	localparam int BOX_W  = mmrq_pkg::box_width(MAILBOXES);
	localparam int PTR_W  = $clog2(SLOTS);
	localparam int WORDS  = MAILBOXES * SLOTS;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [MESSAGE_BITS-1:0] mem [WORDS];
	logic [MESSAGE_BITS-1:0] rdata_q;
	logic [PTR_W-1:0]        rd_ptr_q [MAILBOXES];
	logic [PTR_W-1:0]        wr_ptr_q [MAILBOXES];

	mmrq_pkg::kind_t         kind;
	logic [BOX_W-1:0]        box;
	logic [MESSAGE_BITS-1:0] msg;
	logic [PTR_W-1:0]        head;
	logic [PTR_W-1:0]        tail;
	logic [PTR_W-1:0]        head_nx;
	logic [PTR_W-1:0]        tail_nx;
	logic [ADDR_W-1:0]       wr_addr;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    we;
	logic                    re;
	logic                    adv_head;
	logic [mmrq_pkg::STATUS_W-1:0] status;

	logic                    done_s2;
	logic                    use_rd_s2;
	logic [mmrq_pkg::STATUS_W-1:0] status_s2;

	assign {kind, box, msg} = entry;
	assign pop = valid;

	assign head    = rd_ptr_q[box];
	assign tail    = wr_ptr_q[box];
	assign head_nx = (head == PTR_W'(SLOTS - 1)) ? '0 : head + PTR_W'(1);
	assign tail_nx = (tail == PTR_W'(SLOTS - 1)) ? '0 : tail + PTR_W'(1);
	assign wr_addr = ADDR_W'(int'(box) * SLOTS + int'(tail_nx));
	assign rd_addr = ADDR_W'(int'(box) * SLOTS + int'(head_nx));

	always_comb begin
		status   = mmrq_pkg::ST_OK;
		we       = 1'b0;
		re       = 1'b0;
		adv_head = 1'b0;
		unique case (kind) inside
			mmrq_pkg::K_BAD_ID: status = mmrq_pkg::ST_BAD_ID;
			mmrq_pkg::K_NO_BOX: status = mmrq_pkg::ST_NO_MAILBOX;
			mmrq_pkg::K_SEND: begin
				if (tail_nx == head) begin
					status = mmrq_pkg::ST_OVERFLOW;
				end else begin
					we = valid;
				end
			end
			mmrq_pkg::K_RECV, mmrq_pkg::K_PEEK: begin
				if (head == tail) begin
					status = mmrq_pkg::ST_EMPTY;
				end else begin
					re       = valid;
					adv_head = valid && (kind == mmrq_pkg::K_RECV);
				end
			end
			default: status = mmrq_pkg::ST_OK;
		endcase
	end

	// Message store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= msg;
		end
		if (re) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAILBOXES; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
			end
			done_s2 <= 1'b0;
		end else begin
			if (we) begin
				wr_ptr_q[box] <= tail_nx;
			end
			if (adv_head) begin
				rd_ptr_q[box] <= head_nx;
			end
			done_s2 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		status_s2 <= status;
		use_rd_s2 <= re;
	end

	assign done               = done_s2;
	assign result.status      = status_s2;
	assign result.message_out = use_rd_s2 ? mmrq_pkg::MSG_IN_W'(rdata_q) : '0;

endmodule
`default_nettype wire

FILE: src/mmrq_checker.sv
// Port-level checks for the multi-mailbox ring queue and their bind.
`default_nettype none
module mmrq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire mmrq_pkg::request_t request,
	input wire logic               done,
	input wire mmrq_pkg::result_t  result
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= mmrq_pkg::ST_EMPTY))
		else $error("status code out of range");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != mmrq_pkg::ST_OK) |-> (result.message_out == '0))
		else $error("message not zero on failing status");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after request");

	a_bad_id: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.mailbox_id == '0) |-> ##2
		(done && result.status == mmrq_pkg::ST_BAD_ID))
		else $error("zero id not reported as bad id");

endmodule

bind multi_mailbox_ring_queue mmrq_checker u_mmrq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);
`default_nettype wire
